### sv/sprite_xor_framebuffer_unit_macros.svh
// Assertion macros shared by the framebuffer unit checker.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef SPRITE_XOR_FRAMEBUFFER_UNIT_MACROS_SVH
`define SPRITE_XOR_FRAMEBUFFER_UNIT_MACROS_SVH

// Consequent holds in the same cycle as the antecedent.
`define SXF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SXF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/sxf_pkg.sv
// Shared types and constants for the sprite XOR framebuffer unit.
// No dependencies; every module imports this package.
package sxf_pkg;

    localparam int SCREEN_WIDTH  = 64;
    localparam int SCREEN_HEIGHT = 32;
    localparam int ROW_BITS      = 64;
    localparam int COORD_W       = 8;
    localparam int ROW_W         = (SCREEN_HEIGHT > 1) ? $clog2(SCREEN_HEIGHT) : 1;

    // Columns at or past SCREEN_WIDTH are never shown.
    localparam logic [ROW_BITS-1:0] VISIBLE_MASK = ~({ROW_BITS{1'b1}} >> SCREEN_WIDTH);

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_DRAW  = 2'd1,
        REQ_READ  = 2'd2
    } req_kind_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [COORD_W-1:0] x_pos;
        logic [COORD_W-1:0] y_pos;
        logic [3:0]         row_offset;
        logic [7:0]         sprite_bits;
        logic               last_row;
    } sxf_req_t;

    typedef struct packed {
        logic                collision;
        logic [ROW_BITS-1:0] row_data;
        logic                is_read;
    } sxf_rsp_t;

    // Handoff from the frame core to the result register.
    typedef struct packed {
        logic     has_result;
        sxf_rsp_t rsp;
    } sxf_step_t;

endpackage

### sv/sxf_in_stage.sv
// Input register for the framebuffer unit.
// Depends on sxf_pkg for the request item type.
module sxf_in_stage
    import sxf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  sxf_req_t req_item,
    input  logic     advance,
    output logic     held_valid,
    output sxf_req_t held_item
);

    logic     valid_reg;
    logic     valid_next;
    sxf_req_t item_reg;

    // Hold the item while the core cannot move it on.
    assign req_stall  = valid_reg && !advance;
    assign valid_next = req_stall ? valid_reg : req_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            item_reg <= req_item;
        end
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

### sv/sxf_frame_core.sv
// Pixel row store, XOR draw, collision flag and result forming.
// Depends on sxf_pkg for geometry, request codes and item types.
module sxf_frame_core
    import sxf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      fire,
    input  sxf_req_t  item,
    output sxf_step_t step
);

    logic [ROW_BITS-1:0]      frame_rows_reg [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] row_valid_reg;
    logic [SCREEN_HEIGHT-1:0] row_valid_next;
    logic                     collision_reg;
    logic                     collision_next;

    logic [COORD_W-1:0]  x_mod;
    logic [COORD_W-1:0]  y_mod;
    logic [COORD_W-1:0]  draw_row;
    logic                draw_in_range;
    logic [ROW_W-1:0]    row_idx;
    logic [ROW_BITS-1:0] cur_row;
    logic [ROW_BITS-1:0] sprite_mask;
    logic [ROW_BITS-1:0] new_row;
    logic                hit;
    logic                write_row;

    assign x_mod         = COORD_W'(item.x_pos % SCREEN_WIDTH);
    assign y_mod         = COORD_W'(item.y_pos % SCREEN_HEIGHT);
    assign draw_row      = y_mod + COORD_W'(item.row_offset);
    assign draw_in_range = (draw_row < COORD_W'(SCREEN_HEIGHT));

    // One row address per item: the target row of a draw, else the read row.
    assign row_idx = (item.req_type == REQ_DRAW) ? draw_row[ROW_W-1:0] : y_mod[ROW_W-1:0];
    assign cur_row = row_valid_reg[row_idx] ? frame_rows_reg[row_idx] : '0;

    // Leftmost sprite bit lands at column x_mod; drop what falls off the right edge.
    assign sprite_mask = ({item.sprite_bits, {(ROW_BITS-8){1'b0}}} >> x_mod) & VISIBLE_MASK;
    assign hit         = |(cur_row & sprite_mask);
    assign new_row     = cur_row ^ sprite_mask;

    always_comb
    begin
        row_valid_next  = row_valid_reg;
        collision_next  = collision_reg;
        write_row       = 1'b0;
        step.has_result = 1'b0;
        step.rsp        = '0;
        unique case (item.req_type)
            REQ_CLEAR:
            begin
                row_valid_next  = '0;
                step.has_result = 1'b1;
            end
            REQ_DRAW:
            begin
                if (draw_in_range)
                begin
                    write_row               = 1'b1;
                    row_valid_next[row_idx] = 1'b1;
                end
                if (item.last_row)
                begin
                    step.has_result    = 1'b1;
                    step.rsp.collision = collision_reg || (draw_in_range && hit);
                    collision_next     = 1'b0;
                end
                else if (draw_in_range && hit)
                begin
                    collision_next = 1'b1;
                end
            end
            REQ_READ:
            begin
                step.has_result   = 1'b1;
                step.rsp.row_data = cur_row & VISIBLE_MASK;
                step.rsp.is_read  = 1'b1;
            end
            default:
            begin
                // Unused request code: drop it.
                step.has_result = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            collision_reg <= 1'b0;
        end
        else if (fire)
        begin
            row_valid_reg <= row_valid_next;
            collision_reg <= collision_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && write_row)
        begin
            frame_rows_reg[row_idx] <= new_row;
        end
    end

endmodule

### sv/sxf_out_stage.sv
// Result register for the framebuffer unit.
// Depends on sxf_pkg for the result item and handoff types.
module sxf_out_stage
    import sxf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      held_valid,
    input  sxf_step_t step,
    output logic      advance,
    output logic      fire,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output sxf_rsp_t  rsp_item
);

    logic     valid_reg;
    logic     valid_next;
    sxf_rsp_t item_reg;

    // The slot is free when empty or being taken this cycle.
    assign advance    = !valid_reg || !rsp_stall;
    assign fire       = held_valid && advance;
    assign valid_next = advance ? (fire && step.has_result) : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && step.has_result)
        begin
            item_reg <= step.rsp;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp_item  = item_reg;

endmodule

### sv/sprite_xor_framebuffer_unit.sv
// Sprite XOR framebuffer unit: a 64x32 one-bit screen with XOR sprite drawing.
// Request channel: req_valid / req_stall / req_item carry clear, draw-row and
// read-row requests. Response channel: rsp_valid / rsp_stall / rsp_item carry
// results. An item moves at a clock edge where valid is high and stall is low.
// Clear gives one all-zero result, a draw row gives a result only when it is
// marked last (carrying the sticky collision flag), a read gives the row with
// is_read set. Request code 3 is dropped without a result.
// An accepted item goes through the input register, then the result register.
// Throughput: one item per cycle while rsp_stall is low, set by the single
// read-modify-write of one row between the input and result registers.
// Reset (rst_n low, asynchronous) darkens the screen by clearing per-row valid
// bits and clears the collision flag; the unit takes items right away.
// When rsp_stall holds a result, the next item waits in the input register and
// req_stall rises once that register is also full.
// Depends on sxf_pkg, sxf_in_stage, sxf_frame_core and sxf_out_stage.
module sprite_xor_framebuffer_unit
    import sxf_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  sxf_req_t req_item,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output sxf_rsp_t rsp_item
);

    logic      advance;
    logic      fire;
    logic      held_valid;
    sxf_req_t  held_item;
    sxf_step_t step;

    sxf_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req_item   (req_item),
        .advance    (advance),
        .held_valid (held_valid),
        .held_item  (held_item)
    );

    sxf_frame_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (held_item),
        .step  (step)
    );

    sxf_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .step       (step),
        .advance    (advance),
        .fire       (fire),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp_item   (rsp_item)
    );

endmodule

### sv/sxf_checker.sv
// Port-level checks for the sprite XOR framebuffer unit, bound to the top level.
// Depends on sxf_pkg and sprite_xor_framebuffer_unit_macros.svh.
`include "sprite_xor_framebuffer_unit_macros.svh"

module sxf_checker
    import sxf_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     req_valid,
    input logic     req_stall,
    input sxf_req_t req_item,
    input logic     rsp_valid,
    input logic     rsp_stall,
    input sxf_rsp_t rsp_item
);

    `SXF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")
    `SXF_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall, "request stalled without a stalled response")
    `SXF_ASSERT_NOW(a_read_no_hit, rsp_valid && rsp_item.is_read, !rsp_item.collision, "read response with collision set")
    `SXF_ASSERT_NOW(a_row_only_read, rsp_valid && !rsp_item.is_read, rsp_item.row_data == '0, "row data on a non-read response")

endmodule

bind sprite_xor_framebuffer_unit sxf_checker u_chk (.*);
